// ===== hw/rtl/so3lg_pkg.sv =====
// Shared types and constants for the SO(3) log-map attitude PD controller.
// Holds the request and response words, register indexes and CORDIC angles.
// No dependencies.
package so3lg_pkg;

  typedef struct packed {
    logic signed [15:0] want_qx;
    logic signed [15:0] want_qy;
    logic signed [15:0] want_qz;
    logic signed [15:0] want_qw;
    logic signed [15:0] meas_qx;
    logic signed [15:0] meas_qy;
    logic signed [15:0] meas_qz;
    logic signed [15:0] meas_qw;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] speed_in;
  } req_t;

  typedef struct packed {
    logic signed [15:0] speed_out;
    logic signed [23:0] drive_x;
    logic signed [23:0] drive_y;
    logic signed [23:0] drive_z;
    logic [14:0]        error_angle;
    logic               saturated;
  } rsp_t;

  localparam logic [2:0] REG_GAIN_P_X = 3'd0;
  localparam logic [2:0] REG_GAIN_P_Y = 3'd1;
  localparam logic [2:0] REG_GAIN_P_Z = 3'd2;
  localparam logic [2:0] REG_GAIN_D_X = 3'd3;
  localparam logic [2:0] REG_GAIN_D_Y = 3'd4;
  localparam logic [2:0] REG_GAIN_D_Z = 3'd5;

  localparam logic [15:0] GAIN_P_RESET = 16'd256;
  localparam logic [15:0] GAIN_D_RESET = 16'd0;

  localparam int NSQ_W   = 42;
  localparam int ROOT_W  = 21;
  localparam int SQ_CELLS = 21;
  localparam int CX_W    = 25;
  localparam int Z_W     = 33;
  localparam int NUM_W   = 53;
  localparam int REM_W   = 54;
  localparam int Q_W     = 14;

  localparam logic signed [32:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic signed [32:0] PI_Q30      = 33'sd3373259426;

  localparam logic signed [26:0] DRIVE_MAX = 27'sd8388607;
  localparam logic signed [26:0] DRIVE_MIN = -27'sd8388608;

  function automatic logic [30:0] atan_q30(input int i);
    case (i)
      0: atan_q30 = 31'd843314857;
      1: atan_q30 = 31'd497837829;
      2: atan_q30 = 31'd263043837;
      3: atan_q30 = 31'd133525159;
      4: atan_q30 = 31'd67021687;
      5: atan_q30 = 31'd33543516;
      6: atan_q30 = 31'd16775851;
      7: atan_q30 = 31'd8388437;
      8: atan_q30 = 31'd4194283;
      9: atan_q30 = 31'd2097149;
      default: atan_q30 = (i <= 30) ? (31'd1 << (30 - i)) : '0;
    endcase
  endfunction

endpackage

// ===== hw/rtl/so3_log_attitude_pd_controller.sv =====
// Top level of the SO(3) log-map attitude PD controller.
// Depends on so3lg_pkg and the sqrt, CORDIC and divider cells.
//
// The block takes one request word per cycle while not held and returns one response word per
// request, in order. The pipeline is built from three rows of cells:
// a 21-cell square root, a CORDIC_STEPS-cell arctangent and a 14-cell divider per axis,
// plus nine product and rounding stages. The whole pipeline advances together and
// holds while a finished response waits on rsp_ready. Gains are written through the
// cfg port, indexes 0 to 5; other indexes are ignored.
module so3_log_attitude_pd_controller #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  so3lg_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output so3lg_pkg::rsp_t   rsp,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import so3lg_pkg::*;

  localparam int LAT = 44 + CORDIC_STEPS;

  typedef struct packed {
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] speed;
    logic signed [21:0] ev0;
    logic signed [21:0] ev1;
    logic signed [21:0] ev2;
    logic               flip;
    logic [ROOT_W-1:0]  xabs;
    logic [ROOT_W-1:0]  n;
    logic [2:0]         neg;
    logic [14:0]        ea;
  } side_t;

  logic en;
  logic [LAT-1:0] vld;

  logic [15:0] kp_x, kp_y, kp_z, kd_x, kd_y, kd_z;

  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;
  assign rsp_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_x <= GAIN_P_RESET;
      kp_y <= GAIN_P_RESET;
      kp_z <= GAIN_P_RESET;
      kd_x <= GAIN_D_RESET;
      kd_y <= GAIN_D_RESET;
      kd_z <= GAIN_D_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P_X: kp_x <= cfg_data;
        REG_GAIN_P_Y: kp_y <= cfg_data;
        REG_GAIN_P_Z: kp_z <= cfg_data;
        REG_GAIN_D_X: kd_x <= cfg_data;
        REG_GAIN_D_Y: kd_y <= cfg_data;
        REG_GAIN_D_Z: kd_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], req_valid};
    end
  end

  // Quaternion products and error components.
  logic signed [31:0] p [16];
  side_t sd1, sd2, sd3, sd4;
  side_t sd_req, sd2_next, sd3_next;
  logic signed [33:0] e0, e1, e2, e3;
  logic signed [33:0] t0, t1, t2, t3;
  logic signed [21:0] ew2;
  logic signed [43:0] m0, m1, m2;
  logic [40:0] sq0, sq1, sq2;
  logic [NSQ_W-1:0] nsq;

  always_comb begin
    sd_req        = '0;
    sd_req.rate_x = req.rate_x;
    sd_req.rate_y = req.rate_y;
    sd_req.rate_z = req.rate_z;
    sd_req.speed  = req.speed_in;
  end

  assign e0 = 34'(p[0]) - 34'(p[1]) - 34'(p[2]) + 34'(p[3]);
  assign e1 = 34'(p[4]) - 34'(p[5]) - 34'(p[6]) + 34'(p[7]);
  assign e2 = 34'(p[8]) - 34'(p[9]) - 34'(p[10]) + 34'(p[11]);
  assign e3 = 34'(p[12]) + 34'(p[13]) + 34'(p[14]) + 34'(p[15]);
  assign t0 = e0 + 34'sd2048;
  assign t1 = e1 + 34'sd2048;
  assign t2 = e2 + 34'sd2048;
  assign t3 = e3 + 34'sd2048;

  assign m0 = 44'(sd2.ev0) * 44'(sd2.ev0);
  assign m1 = 44'(sd2.ev1) * 44'(sd2.ev1);
  assign m2 = 44'(sd2.ev2) * 44'(sd2.ev2);

  always_comb begin
    sd2_next     = sd1;
    sd2_next.ev0 = t0[33:12];
    sd2_next.ev1 = t1[33:12];
    sd2_next.ev2 = t2[33:12];
    sd3_next      = sd2;
    sd3_next.flip = ew2 < 0;
    sd3_next.xabs = (ew2 < 0) ? ROOT_W'(-ew2) : ROOT_W'(ew2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0]  <= 32'(req.meas_qw) * 32'(req.want_qx);
      p[1]  <= 32'(req.want_qw) * 32'(req.meas_qx);
      p[2]  <= 32'(req.meas_qy) * 32'(req.want_qz);
      p[3]  <= 32'(req.meas_qz) * 32'(req.want_qy);
      p[4]  <= 32'(req.meas_qw) * 32'(req.want_qy);
      p[5]  <= 32'(req.want_qw) * 32'(req.meas_qy);
      p[6]  <= 32'(req.meas_qz) * 32'(req.want_qx);
      p[7]  <= 32'(req.meas_qx) * 32'(req.want_qz);
      p[8]  <= 32'(req.meas_qw) * 32'(req.want_qz);
      p[9]  <= 32'(req.want_qw) * 32'(req.meas_qz);
      p[10] <= 32'(req.meas_qx) * 32'(req.want_qy);
      p[11] <= 32'(req.meas_qy) * 32'(req.want_qx);
      p[12] <= 32'(req.meas_qw) * 32'(req.want_qw);
      p[13] <= 32'(req.meas_qx) * 32'(req.want_qx);
      p[14] <= 32'(req.meas_qy) * 32'(req.want_qy);
      p[15] <= 32'(req.meas_qz) * 32'(req.want_qz);
      sd1   <= sd_req;

      sd2 <= sd2_next;
      ew2 <= t3[33:12];

      sq0 <= m0[40:0];
      sq1 <= m1[40:0];
      sq2 <= m2[40:0];
      sd3 <= sd3_next;

      nsq <= NSQ_W'(sq0) + NSQ_W'(sq1) + NSQ_W'(sq2);
      sd4 <= sd3;
    end
  end

  // Square root row.
  logic [NSQ_W-1:0] sv [SQ_CELLS+1];
  logic [NSQ_W-1:0] sr [SQ_CELLS+1];
  side_t sq_side [SQ_CELLS];

  assign sv[0] = nsq;
  assign sr[0] = '0;

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
    so3lg_sqrt_cell #(.BEXP(2 * (SQ_CELLS - 1 - k))) u_cell (
      .clk   (clk),
      .en    (en),
      .v_in  (sv[k]),
      .r_in  (sr[k]),
      .v_out (sv[k+1]),
      .r_out (sr[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side[0] <= sd4;
      for (int k = 1; k < SQ_CELLS; k++) begin
        sq_side[k] <= sq_side[k-1];
      end
    end
  end

  // Arctangent row.
  side_t sd_root;
  logic signed [CX_W-1:0] cx [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] cy [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  cz [CORDIC_STEPS+1];
  side_t co_side [CORDIC_STEPS];

  always_comb begin
    sd_root   = sq_side[SQ_CELLS-1];
    sd_root.n = sr[SQ_CELLS][ROOT_W-1:0];
  end

  assign cx[0] = $signed(CX_W'(sd_root.xabs));
  assign cy[0] = $signed(CX_W'(sd_root.n));
  assign cz[0] = '0;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    so3lg_cordic_cell #(.STEP(k)) u_cell (
      .clk   (clk),
      .en    (en),
      .x_in  (cx[k]),
      .y_in  (cy[k]),
      .z_in  (cz[k]),
      .x_out (cx[k+1]),
      .y_out (cy[k+1]),
      .z_out (cz[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      co_side[0] <= sd_root;
      for (int k = 1; k < CORDIC_STEPS; k++) begin
        co_side[k] <= co_side[k-1];
      end
    end
  end

  // Angle clamp, reported angle and numerators.
  side_t sd_co, sd5, sd6, sd5_next, sd6_next;
  logic signed [Z_W-1:0] zc, zf, zfull;
  logic [34:0] ea_sum;
  logic [31:0] ang;
  logic [ROOT_W-1:0] mag0, mag1, mag2;
  logic [NUM_W-1:0] num0, num1, num2;

  assign sd_co = co_side[CORDIC_STEPS-1];
  assign zc    = cz[CORDIC_STEPS];

  always_comb begin
    if (sd_co.n == '0 || zc < 0) begin
      zf = '0;
    end else if (zc > HALF_PI_Q30) begin
      zf = HALF_PI_Q30;
    end else begin
      zf = zc;
    end
    zfull  = sd_co.flip ? (PI_Q30 - zf) : zf;
    ea_sum = (35'(zfull) << 1) + 35'd131072;
  end

  assign mag0 = (sd5.ev0 < 0) ? ROOT_W'(-sd5.ev0) : ROOT_W'(sd5.ev0);
  assign mag1 = (sd5.ev1 < 0) ? ROOT_W'(-sd5.ev1) : ROOT_W'(sd5.ev1);
  assign mag2 = (sd5.ev2 < 0) ? ROOT_W'(-sd5.ev2) : ROOT_W'(sd5.ev2);

  always_comb begin
    sd5_next     = sd_co;
    sd5_next.ea  = ea_sum[32:18];
    sd6_next     = sd5;
    sd6_next.neg = sd5.flip ? {sd5.ev2 > 0, sd5.ev1 > 0, sd5.ev0 > 0}
                            : {sd5.ev2 < 0, sd5.ev1 < 0, sd5.ev0 < 0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd5 <= sd5_next;
      ang <= 32'(zf) << 1;

      num0 <= NUM_W'(mag0) * NUM_W'(ang);
      num1 <= NUM_W'(mag1) * NUM_W'(ang);
      num2 <= NUM_W'(mag2) * NUM_W'(ang);
      sd6  <= sd6_next;
    end
  end

  // Divider rows, one per axis.
  logic [REM_W-1:0]  drem [3][Q_W+1];
  logic [ROOT_W-1:0] dn   [3][Q_W+1];
  logic [Q_W-1:0]    dq   [3][Q_W+1];
  side_t dv_side [Q_W];

  assign drem[0][0] = REM_W'(num0) + (REM_W'(sd6.n) << 17);
  assign drem[1][0] = REM_W'(num1) + (REM_W'(sd6.n) << 17);
  assign drem[2][0] = REM_W'(num2) + (REM_W'(sd6.n) << 17);

  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign dn[a][0] = sd6.n;
    assign dq[a][0] = '0;
    for (genvar k = 0; k < Q_W; k++) begin : g_div
      so3lg_div_cell #(.BITPOS(Q_W - 1 - k)) u_cell (
        .clk     (clk),
        .en      (en),
        .rem_in  (drem[a][k]),
        .n_in    (dn[a][k]),
        .q_in    (dq[a][k]),
        .rem_out (drem[a][k+1]),
        .n_out   (dn[a][k+1]),
        .q_out   (dq[a][k+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0] <= sd6;
      for (int k = 1; k < Q_W; k++) begin
        dv_side[k] <= dv_side[k-1];
      end
    end
  end

  // Signed rotation vector, gain products and output rounding.
  side_t sd_dv, sd7, sd8;
  logic signed [15:0] rv0, rv1, rv2;
  logic signed [15:0] r0, r1, r2;
  logic signed [32:0] pk0, pk1, pk2, dk0, dk1, dk2;
  logic signed [34:0] acc0, acc1, acc2;
  logic signed [26:0] d0, d1, d2;
  logic [23:0] o0, o1, o2;
  logic s0, s1, s2;
  rsp_t rsp_next;

  assign sd_dv = dv_side[Q_W-1];

  always_comb begin
    rv0 = sd_dv.neg[0] ? -$signed(16'(dq[0][Q_W])) : $signed(16'(dq[0][Q_W]));
    rv1 = sd_dv.neg[1] ? -$signed(16'(dq[1][Q_W])) : $signed(16'(dq[1][Q_W]));
    rv2 = sd_dv.neg[2] ? -$signed(16'(dq[2][Q_W])) : $signed(16'(dq[2][Q_W]));
    if (sd_dv.n == '0) begin
      rv0 = '0;
      rv1 = '0;
      rv2 = '0;
    end
  end

  assign acc0 = 35'(pk0) + (35'(dk0) <<< 1) + 35'sd128;
  assign acc1 = 35'(pk1) + (35'(dk1) <<< 1) + 35'sd128;
  assign acc2 = 35'(pk2) + (35'(dk2) <<< 1) + 35'sd128;
  assign d0 = acc0[34:8];
  assign d1 = acc1[34:8];
  assign d2 = acc2[34:8];

  always_comb begin
    s0 = (d0 > DRIVE_MAX) || (d0 < DRIVE_MIN);
    s1 = (d1 > DRIVE_MAX) || (d1 < DRIVE_MIN);
    s2 = (d2 > DRIVE_MAX) || (d2 < DRIVE_MIN);
    o0 = (d0 > DRIVE_MAX) ? 24'(DRIVE_MAX) : (d0 < DRIVE_MIN) ? 24'(DRIVE_MIN) : d0[23:0];
    o1 = (d1 > DRIVE_MAX) ? 24'(DRIVE_MAX) : (d1 < DRIVE_MIN) ? 24'(DRIVE_MIN) : d1[23:0];
    o2 = (d2 > DRIVE_MAX) ? 24'(DRIVE_MAX) : (d2 < DRIVE_MIN) ? 24'(DRIVE_MIN) : d2[23:0];
  end

  always_comb begin
    rsp_next             = '0;
    rsp_next.speed_out   = sd8.speed;
    rsp_next.drive_x     = o0;
    rsp_next.drive_y     = o1;
    rsp_next.drive_z     = o2;
    rsp_next.error_angle = sd8.ea;
    rsp_next.saturated   = s0 || s1 || s2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0  <= rv0;
      r1  <= rv1;
      r2  <= rv2;
      sd7 <= sd_dv;

      pk0 <= 33'($signed({1'b0, kp_x})) * 33'(r0);
      pk1 <= 33'($signed({1'b0, kp_y})) * 33'(r1);
      pk2 <= 33'($signed({1'b0, kp_z})) * 33'(r2);
      dk0 <= 33'($signed({1'b0, kd_x})) * 33'(sd7.rate_x);
      dk1 <= 33'($signed({1'b0, kd_y})) * 33'(sd7.rate_y);
      dk2 <= 33'($signed({1'b0, kd_z})) * 33'(sd7.rate_z);
      sd8 <= sd7;

      rsp <= rsp_next;
    end
  end

endmodule

// ===== hw/rtl/so3lg_sqrt_cell.sv =====
// One digit step of the integer square root chain.
// Depends on so3lg_pkg for widths.
module so3lg_sqrt_cell #(
  parameter int BEXP = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [so3lg_pkg::NSQ_W-1:0]   v_in,
  input  logic [so3lg_pkg::NSQ_W-1:0]   r_in,
  output logic [so3lg_pkg::NSQ_W-1:0]   v_out,
  output logic [so3lg_pkg::NSQ_W-1:0]   r_out
);
  import so3lg_pkg::*;

  localparam logic [NSQ_W-1:0] BIT = NSQ_W'(1) << BEXP;

  logic [NSQ_W-1:0] trial;

  assign trial = r_in + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (v_in >= trial) begin
        v_out <= v_in - trial;
        r_out <= (r_in >> 1) + BIT;
      end else begin
        v_out <= v_in;
        r_out <= r_in >> 1;
      end
    end
  end

endmodule

// ===== hw/rtl/so3lg_cordic_cell.sv =====
// One vectoring CORDIC rotation with a fixed shift and angle.
// Depends on so3lg_pkg for widths and the arctangent constants.
module so3lg_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [so3lg_pkg::CX_W-1:0]  x_in,
  input  logic signed [so3lg_pkg::CX_W-1:0]  y_in,
  input  logic signed [so3lg_pkg::Z_W-1:0]   z_in,
  output logic signed [so3lg_pkg::CX_W-1:0]  x_out,
  output logic signed [so3lg_pkg::CX_W-1:0]  y_out,
  output logic signed [so3lg_pkg::Z_W-1:0]   z_out
);
  import so3lg_pkg::*;

  localparam logic signed [Z_W-1:0] ANG = $signed(Z_W'(atan_q30(STEP)));

  logic signed [CX_W-1:0] xs;
  logic signed [CX_W-1:0] ys;

  assign xs = x_in >>> STEP;
  assign ys = y_in >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in > 0) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ANG;
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ANG;
      end
    end
  end

endmodule

// ===== hw/rtl/so3lg_div_cell.sv =====
// One restoring division step producing a single quotient bit.
// Depends on so3lg_pkg for widths.
module so3lg_div_cell #(
  parameter int BITPOS = 0
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [so3lg_pkg::REM_W-1:0]     rem_in,
  input  logic [so3lg_pkg::ROOT_W-1:0]    n_in,
  input  logic [so3lg_pkg::Q_W-1:0]       q_in,
  output logic [so3lg_pkg::REM_W-1:0]     rem_out,
  output logic [so3lg_pkg::ROOT_W-1:0]    n_out,
  output logic [so3lg_pkg::Q_W-1:0]       q_out
);
  import so3lg_pkg::*;

  logic [REM_W-1:0] dsub;

  assign dsub = REM_W'(n_in) << (18 + BITPOS);

  always_ff @(posedge clk) begin
    if (en) begin
      n_out <= n_in;
      if (rem_in >= dsub) begin
        rem_out <= rem_in - dsub;
        q_out   <= q_in | (Q_W'(1) << BITPOS);
      end else begin
        rem_out <= rem_in;
        q_out   <= q_in;
      end
    end
  end

endmodule
